// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers for the rtl
// implication checks with and without reset masking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("%m: same-cycle implication failed");

// next-cycle implication, checked during reset as well
`define ASSERT_NEXT(label, clk, cond, expr) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error("%m: next-cycle implication failed");

`endif

// ----- rtl/dds_pkg.sv -----
// ----------------------------------------------------------------------------
// dds_pkg: shared constants and types for the decimal digit slice
// sizes of the conversion chains and the payloads that move between cells
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

   localparam int VALUE_BITS = 32;
   localparam int NUM_BITS   = 32;
   localparam int IN_BITS    = (VALUE_BITS < NUM_BITS) ? VALUE_BITS : NUM_BITS;
   localparam int FIELD_W    = 4;
   localparam int OUT_BITS   = 32;

   // request item layout
   localparam int START_LSB  = NUM_BITS;
   localparam int LEN_LSB    = START_LSB + FIELD_W;
   localparam int REQ_DATA_W = ((LEN_LSB + FIELD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = OUT_BITS;

   // shift-and-add-3 chain: binary bits handled per cell
   localparam int DAB_STEPS = 4;
   localparam int DAB_CELLS = (IN_BITS + DAB_STEPS - 1) / DAB_STEPS;
   localparam int PAD_BITS  = DAB_CELLS * DAB_STEPS;

   // decimal digits of the largest value
   function automatic int max_digits(input int bits);
      logic [64:0] v;
      int          n;
      v = (65'd1 << bits) - 65'd1;
      n = 1;
      for (int i = 0; i < 20; i++) begin
         if (v >= 65'd10) begin
            v = v / 65'd10;
            n++;
         end
      end
      return n;
   endfunction

   localparam int DIGITS   = max_digits(IN_BITS);
   localparam int BCD_BITS = 4 * DIGITS;
   localparam int POS_W    = $clog2(DIGITS + 1);
   localparam int SUM_W    = ((POS_W > FIELD_W) ? POS_W : FIELD_W) + 1;

   typedef struct packed {
      logic [PAD_BITS-1:0] bin;
      logic [BCD_BITS-1:0] bcd;
      logic [FIELD_W-1:0]  start;
      logic [FIELD_W-1:0]  len;
   } dab_type;

   typedef struct packed {
      logic [BCD_BITS-1:0] bcd;
      logic [POS_W-1:0]    pos;
      logic [POS_W-1:0]    lo;
      logic [POS_W-1:0]    hi;
      logic                bad;
      logic [OUT_BITS-1:0] acc;
   } hor_type;

   function automatic logic [3:0] add3(input logic [3:0] d);
      return (d >= 4'd5) ? d + 4'd3 : d;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/decimal_digit_slice.sv -----
// ----------------------------------------------------------------------------
// decimal_digit_slice: run of decimal digits out of a binary value
// converts a value to decimal digits, picks a run and returns it in binary
// ----------------------------------------------------------------------------
// Each request item carries a 32-bit unsigned value, a start position
// counted from 1 at the most significant decimal digit, and a run length.
// The response item is the binary value of that run of decimal digits;
// zero counts as one digit. A start of zero, or a run that reaches past
// the last digit, gives slice value 0 with out_of_range set; an empty run
// inside the digits gives 0 with out_of_range clear. The path is a row of
// cells: 8 shift-and-add-3 cells (4 binary bits each), one digit-count
// and bounds stage, then 10 multiply-by-ten cells (one decimal digit
// each). Every cell is a register, and a new item is taken every cycle
// while the response side takes items. Each cell has its own valid bit,
// so a stalled response only holds the cells that are full; the last
// cell doubles as the output register. No state survives an item and
// reset only clears the valid bits.
`default_nettype none

module decimal_digit_slice (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [dds_pkg::REQ_DATA_W-1:0] req_tdata,  // number_in, start_pos, run_len
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [dds_pkg::RSP_DATA_W-1:0] rsp_tdata,  // slice_value
   output logic        rsp_tuser                      // out_of_range
);
   import dds_pkg::*;

   `include "assert_macros.svh"

   // binary to bcd chain, link 0 is the request port
   logic    dab_valid [0:DAB_CELLS];
   logic    dab_ready [0:DAB_CELLS];
   dab_type dab_data  [0:DAB_CELLS];

   // bcd to binary chain, last link is the response port
   logic    hor_valid [0:DIGITS];
   logic    hor_ready [0:DIGITS];
   hor_type hor_data  [0:DIGITS];

   always_comb begin
      dab_valid[0]      = req_tvalid;
      dab_data[0].bin   = PAD_BITS'(req_tdata[IN_BITS-1:0]);
      dab_data[0].bcd   = '0;
      dab_data[0].start = req_tdata[START_LSB +: FIELD_W];
      dab_data[0].len   = req_tdata[LEN_LSB +: FIELD_W];
      req_tready        = dab_ready[0];
   end

   genvar gi;
   generate
      for (gi = 0; gi < DAB_CELLS; gi++) begin : g_dabble
         dds_dabble_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .up_valid (dab_valid[gi]),
            .up_ready (dab_ready[gi]),
            .up_data  (dab_data[gi]),
            .dn_valid (dab_valid[gi+1]),
            .dn_ready (dab_ready[gi+1]),
            .dn_data  (dab_data[gi+1])
         );
      end
   endgenerate

   // digit count and run window
   dds_select u_select (
      .clock    (clock),
      .reset    (reset),
      .up_valid (dab_valid[DAB_CELLS]),
      .up_ready (dab_ready[DAB_CELLS]),
      .up_data  (dab_data[DAB_CELLS]),
      .dn_valid (hor_valid[0]),
      .dn_ready (hor_ready[0]),
      .dn_data  (hor_data[0])
   );

   generate
      for (gi = 0; gi < DIGITS; gi++) begin : g_horner
         dds_horner_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .up_valid (hor_valid[gi]),
            .up_ready (hor_ready[gi]),
            .up_data  (hor_data[gi]),
            .dn_valid (hor_valid[gi+1]),
            .dn_ready (hor_ready[gi+1]),
            .dn_data  (hor_data[gi+1])
         );
      end
   endgenerate

   always_comb begin
      hor_ready[DIGITS] = rsp_tready;
      rsp_tvalid        = hor_valid[DIGITS];
      rsp_tdata         = RSP_DATA_W'(hor_data[DIGITS].acc);
      rsp_tuser         = hor_data[DIGITS].bad;
   end

   // a rejected run never folds a digit in
   `ASSERT_IMPLY(a_oor_is_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   // with the output free every cell can move, so the request side is open
   `ASSERT_IMPLY(a_ready_when_free, clock, reset, !rsp_tvalid || rsp_tready, req_tready)
   // no response comes out of a reset cycle
   `ASSERT_NEXT(a_empty_after_reset, clock, reset, !rsp_tvalid)

endmodule

`default_nettype wire

// ----- rtl/dds_dabble_cell.sv -----
// ----------------------------------------------------------------------------
// dds_dabble_cell: one link of the binary to bcd chain
// shifts a few binary bits into the bcd digits, add-3 before each shift
// ----------------------------------------------------------------------------
`default_nettype none

module dds_dabble_cell (
   input  wire              clock,
   input  wire              reset,
   input  wire              up_valid,
   output logic             up_ready,
   input  wire dds_pkg::dab_type up_data,
   output logic             dn_valid,
   input  wire              dn_ready,
   output dds_pkg::dab_type dn_data
);
   import dds_pkg::*;

   logic                valid_ff, valid_in;
   dab_type             data_ff, data_in;
   logic [PAD_BITS-1:0] bin_w;
   logic [BCD_BITS-1:0] bcd_w;

   always_comb begin
      up_ready = !valid_ff || dn_ready;
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_comb begin
      bin_w = up_data.bin;
      bcd_w = up_data.bcd;
      for (int s = 0; s < DAB_STEPS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            bcd_w[4*d +: 4] = add3(bcd_w[4*d +: 4]);
         end
         {bcd_w, bin_w} = {bcd_w[BCD_BITS-2:0], bin_w, 1'b0};
      end
      data_in       = up_data;
      data_in.bin   = bin_w;
      data_in.bcd   = bcd_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/dds_select.sv -----
// ----------------------------------------------------------------------------
// dds_select: digit count and run bounds
// counts the decimal digits, checks the run and sets its digit window
// ----------------------------------------------------------------------------
`default_nettype none

module dds_select (
   input  wire              clock,
   input  wire              reset,
   input  wire              up_valid,
   output logic             up_ready,
   input  wire dds_pkg::dab_type up_data,
   output logic             dn_valid,
   input  wire              dn_ready,
   output dds_pkg::hor_type dn_data
);
   import dds_pkg::*;

   logic             valid_ff, valid_in;
   hor_type          data_ff, data_in;
   logic [POS_W-1:0] cnt;
   logic [SUM_W-1:0] cnt_s, start_s, len_s, end_s;

   always_comb begin
      up_ready = !valid_ff || dn_ready;
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_comb begin
      // zero still counts as one digit
      cnt = POS_W'(1);
      for (int d = 1; d < DIGITS; d++) begin
         if (up_data.bcd[4*d +: 4] != 4'd0) begin
            cnt = POS_W'(d + 1);
         end
      end
      cnt_s   = SUM_W'(cnt);
      start_s = SUM_W'(up_data.start);
      len_s   = SUM_W'(up_data.len);
      end_s   = start_s - SUM_W'(1) + len_s;

      data_in.bcd = up_data.bcd;
      data_in.pos = POS_W'(DIGITS - 1);
      data_in.bad = (up_data.start == '0) || (end_s > cnt_s);
      data_in.lo  = POS_W'(cnt_s - end_s);
      data_in.hi  = POS_W'(cnt_s - start_s + SUM_W'(1));
      data_in.acc = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/dds_horner_cell.sv -----
// ----------------------------------------------------------------------------
// dds_horner_cell: one link of the bcd to binary chain
// takes the top digit, folds it into the sum when it lies in the run
// ----------------------------------------------------------------------------
`default_nettype none

module dds_horner_cell (
   input  wire              clock,
   input  wire              reset,
   input  wire              up_valid,
   output logic             up_ready,
   input  wire dds_pkg::hor_type up_data,
   output logic             dn_valid,
   input  wire              dn_ready,
   output dds_pkg::hor_type dn_data
);
   import dds_pkg::*;

   logic       valid_ff, valid_in;
   hor_type    data_ff, data_in;
   logic [3:0] digit;
   logic       keep;

   always_comb begin
      up_ready = !valid_ff || dn_ready;
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_comb begin
      digit   = up_data.bcd[BCD_BITS-1 -: 4];
      keep    = !up_data.bad && (up_data.pos >= up_data.lo) && (up_data.pos < up_data.hi);
      data_in = up_data;
      data_in.bcd = {up_data.bcd[BCD_BITS-5:0], 4'd0};
      data_in.pos = up_data.pos - POS_W'(1);
      // acc * 10 + digit, wraps at the output width
      if (keep) begin
         data_in.acc = (up_data.acc << 3) + (up_data.acc << 1) + OUT_BITS'(digit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for decimal_digit_slice
// sends value/start/length items, predicts each digit run and compares the
// slice value and out-of-range flag of every response item in order
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W      = dds_pkg::REQ_DATA_W;
   localparam int RSP_W      = dds_pkg::RSP_DATA_W;
   localparam int DRAIN      = 40;       // well past the depth of the pipeline
   localparam int CYCLE_MAX  = 400000;

   typedef struct packed {
      logic [31:0] slice_value;
      logic        out_of_range;
   } digit_run_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;    // number_in, start_pos, run_len
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;          // slice_value
   logic             rsp_tuser;          // out_of_range

   digit_run_type    expected_runs[$];
   int               fail_count  = 0;
   int               cycle_count = 0;
   int               burst_left  = 0;
   logic [15:0]      ready_pattern = 16'hffff;
   int               pattern_age   = 0;

   decimal_digit_slice DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned ten_to(input int n);
      longint unsigned p;
      p = 1;
      repeat (n) p = p * 10;
      return p;
   endfunction

   // expected slice of the decimal digits of value
   function automatic digit_run_type predict_run(input logic [31:0] value,
                                                 input logic [3:0] start,
                                                 input logic [3:0] len);
      longint unsigned q;
      int              digits;
      int              s;
      int              l;
      digit_run_type   r;
      q      = value;
      digits = 1;
      while (q >= 10) begin
         q = q / 10;
         digits++;
      end
      s = start;
      l = len;
      r = '0;
      if (s == 0 || l > digits || s - 1 + l > digits) begin
         r.out_of_range = 1'b1;
      end else begin
         q = value;
         repeat (digits - (s - 1) - l) q = q / 10;
         r.slice_value = 32'(q % ten_to(l));
      end
      return r;
   endfunction

   // response check first, then record the prediction for a new request
   always @(posedge clock) begin
      digit_run_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_runs.size() == 0) begin
               $display("%0t: unexpected item slice=%0d oor=%0b", $time, rsp_tdata,
                        rsp_tuser);
               fail_count++;
            end else begin
               want = expected_runs.pop_front();
               if (rsp_tdata !== want.slice_value) begin
                  $display("%0t: slice_value expected %0d actual %0d", $time,
                           want.slice_value, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.out_of_range) begin
                  $display("%0t: out_of_range expected %0b actual %0b", $time,
                           want.out_of_range, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_runs.push_back(predict_run(req_tdata[31:0],
                                                req_tdata[dds_pkg::START_LSB +: 4],
                                                req_tdata[dds_pkg::LEN_LSB +: 4]));
      end
   end

   // receiver stalls follow a rotating pattern, reloaded now and then;
   // all-ones patterns give stretches with no back-pressure
   always @(negedge clock) begin
      if (pattern_age == 0) begin
         pattern_age <= $urandom_range(40, 200);
         case ($urandom_range(0, 3))
            0:       ready_pattern <= 16'hffff;
            1:       ready_pattern <= 16'(1 << $urandom_range(0, 15));
            default: ready_pattern <= 16'($urandom) | 16'h0001;
         endcase
      end else begin
         pattern_age   <= pattern_age - 1;
         ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
      end
      rsp_tready <= !reset && ready_pattern[0];
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_MAX) begin
         $display("Verification failed");
         $finish;
      end
   end

   // one request item; called and returns at a falling edge
   task automatic send_slice_request(input logic [31:0] value,
                                     input logic [3:0] start,
                                     input logic [3:0] len);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({len, start, value});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   // field extremes and each special case
   task automatic test_edges();
      send_slice_request(32'd0, 4'd1, 4'd1);             // zero is one digit
      send_slice_request(32'd0, 4'd1, 4'd0);             // empty run
      send_slice_request(32'd0, 4'd2, 4'd0);             // empty run after last digit
      send_slice_request(32'd0, 4'd0, 4'd0);             // start of zero
      send_slice_request(32'd0, 4'd0, 4'd1);
      send_slice_request(32'd0, 4'd1, 4'd2);             // run longer than value
      send_slice_request(32'hffffffff, 4'd1, 4'd10);     // whole largest value
      send_slice_request(32'hffffffff, 4'd1, 4'd11);
      send_slice_request(32'hffffffff, 4'd11, 4'd0);
      send_slice_request(32'hffffffff, 4'd12, 4'd0);
      send_slice_request(32'hffffffff, 4'd15, 4'd15);
      send_slice_request(32'hffffffff, 4'd10, 4'd1);
      send_slice_request(32'hffffffff, 4'd3, 4'd4);
      send_slice_request(32'hffffffff, 4'd5, 4'd6);      // run ends on last digit
      send_slice_request(32'hffffffff, 4'd6, 4'd6);      // run past last digit
      send_slice_request(32'd1234567890, 4'd2, 4'd9);
      send_slice_request(32'd9, 4'd1, 4'd1);
      send_slice_request(32'd10, 4'd2, 4'd1);
      send_slice_request(32'd999999999, 4'd1, 4'd9);
      send_slice_request(32'd1000000000, 4'd1, 4'd10);
      send_slice_request(32'd1000000000, 4'd0, 4'd15);
   endtask

   // runs that lie inside the digits of a value of random length
   task automatic test_wellformed_runs(input int count);
      int              d;
      int              s;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned v;
      repeat (count) begin
         d  = $urandom_range(1, 10);
         lo = (d == 1) ? 0 : ten_to(d - 1);
         hi = ten_to(d) - 1;
         if (hi > 64'hffffffff) hi = 64'hffffffff;
         v  = lo + (longint'($urandom) % (hi - lo + 1));
         s  = $urandom_range(1, d);
         send_slice_request(32'(v), 4'(s), 4'($urandom_range(0, d - s + 1)));
      end
   endtask

   // unconstrained fields, mostly out of range
   task automatic test_raw_fields(input int count);
      logic [31:0] v;
      repeat (count) begin
         v = $urandom;
         if ($urandom_range(0, 1) == 0) v = v >> $urandom_range(0, 31);
         send_slice_request(v, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_edges();
      test_wellformed_runs(800);
      test_raw_fields(300);
      req_tvalid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
